FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define QMT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define QMT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: hw/rtl/qmt_pkg.sv
package qmt_pkg;

    localparam int DEPTH    = 64;
    localparam int KEY_BITS = 64;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        OP_TRACK   = 2'd0,
        OP_UNTRACK = 2'd1,
        OP_DROP    = 2'd2,
        OP_RESP    = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_DELIVER   = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EXPIRED   = 3'd4,
        ST_NO_MATCH  = 3'd5
    } t_status;

    // Register indexes on the configuration port
    localparam logic REG_WILDCARD = 1'b0;
    localparam logic REG_DATA     = 1'b1;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [7:0]          btype;
        logic [7:0]          client;
    } t_entry;

    // Broadcast control for the row of cells
    typedef struct packed {
        logic             sel;     // bank that holds the live list
        logic             push;    // shift live bank toward the tail, new word at cell 0
        logic             shift;   // shift live bank toward cell 0
        logic             append;  // write head word into other bank at plen
        logic             rotate;  // rotate the first plen words of other bank left
        logic [CNT_W-1:0] plen;
    } t_cell_ctl;

endpackage

FILE: hw/rtl/qmt_cell.sv
module qmt_cell import qmt_pkg::*; (
    input  logic             i_clk,
    input  logic [IDX_W-1:0] i_idx,
    input  t_cell_ctl        i_ctl,
    input  t_entry           i_left_live,
    input  t_entry           i_right_live,
    input  t_entry           i_right_dst,
    input  t_entry           i_head,
    input  t_entry           i_first_dst,
    output t_entry           o_live,
    output t_entry           o_dst
);

    t_entry           r_bank0;
    t_entry           r_bank1;
    t_entry           n_bank0;
    t_entry           n_bank1;
    t_entry           n_live;
    t_entry           n_dst;
    logic [CNT_W-1:0] w_pos;
    logic [CNT_W-1:0] w_plen_m1;

    assign o_live    = i_ctl.sel ? r_bank1 : r_bank0;
    assign o_dst     = i_ctl.sel ? r_bank0 : r_bank1;
    assign w_pos     = CNT_W'(i_idx);
    assign w_plen_m1 = i_ctl.plen - CNT_W'(1);

    // Pick the next word for each bank from neighbors or the head
    always_comb begin
        n_live = o_live;
        n_dst  = o_dst;
        if (i_ctl.push) begin
            n_live = i_left_live;
        end else if (i_ctl.shift) begin
            n_live = i_right_live;
        end
        if (i_ctl.append && (w_pos == i_ctl.plen)) begin
            n_dst = i_head;
        end else if (i_ctl.rotate) begin
            if (w_pos == w_plen_m1) begin
                n_dst = i_first_dst;
            end else if (w_pos < i_ctl.plen) begin
                n_dst = i_right_dst;
            end
        end
        n_bank0 = i_ctl.sel ? n_dst  : n_live;
        n_bank1 = i_ctl.sel ? n_live : n_dst;
    end

    always_ff @(posedge i_clk) begin
        r_bank0 <= n_bank0;
        r_bank1 <= n_bank1;
    end

endmodule

FILE: hw/rtl/query_match_table.sv
// Channel  | valid        | stall        | words
// ---------+--------------+--------------+----------------------------------------------
// input    | i_in_valid   | o_in_stall   | opcode, key, block_type, client_id, times
// output   | o_out_valid  | i_out_stall  | status, dest_client, removed_count, last
// config   | psel/penable | pready = 1   | wildcard_type at 0x0, data_type at 0x4
//
// One item at a time. Track and expired responses skip the scan and go to output.
// Untrack, drop and response scan the whole list: the list streams out
// of cell 0 of one bank of the cell row, one word a cycle, into the other bank.
// A stalled output pauses the stream when a second deliver word is waiting.
// Reset is synchronous and empties the table; entry contents are not cleared.
module query_match_table import qmt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_opcode,
    input  logic [63:0]         i_key,
    input  logic [7:0]          i_block_type,
    input  logic [7:0]          i_client_id,
    input  logic [63:0]         i_expiry_time,
    input  logic [63:0]         i_now_time,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [2:0]          o_status,
    output logic [7:0]          o_dest_client,
    output logic [6:0]          o_removed_count,
    output logic                o_last,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic                r_sel, n_sel;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_ulen, n_ulen;
    logic [CNT_W-1:0]    r_plen, n_plen;
    logic [CNT_W-1:0]    r_removed, n_removed;
    logic                r_found, n_found;
    logic                r_pend_v, n_pend_v;
    logic [7:0]          r_pend_client, n_pend_client;
    logic                r_expired;
    t_opcode             r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [7:0]          r_btype;
    logic [7:0]          r_client;
    logic [7:0]          r_wild;
    logic [7:0]          r_data;
    logic                r_out_valid, n_out_valid;
    t_status             r_status, n_status;
    logic [7:0]          r_dest, n_dest;
    logic [CNT_W-1:0]    r_rem_out, n_rem_out;
    logic                r_last, n_last;

    t_cell_ctl           w_ctl;
    t_entry              w_live [DEPTH];
    t_entry              w_dst  [DEPTH];
    t_entry              w_new;
    t_entry              w_head;
    logic                w_accept;
    logic                w_out_free;
    logic                w_match_uk;
    logic                w_match_cl;
    logic                w_hit;
    logic                w_remove;
    logic                w_need_out;
    logic                w_cfg_wr;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_new      = '{key: r_key, btype: r_btype, client: r_client};
    assign w_head     = w_live[0];

    // Row of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry w_left;
        t_entry w_rlive;
        t_entry w_rdst;
        if (g == 0) begin : g_first
            assign w_left = w_new;
        end else begin : g_mid
            assign w_left = w_live[g-1];
        end
        if (g == DEPTH - 1) begin : g_end
            assign w_rlive = '0;
            assign w_rdst  = '0;
        end else begin : g_inner
            assign w_rlive = w_live[g+1];
            assign w_rdst  = w_dst[g+1];
        end
        qmt_cell u_cell (
            .i_clk        (i_clk),
            .i_idx        (IDX_W'(g)),
            .i_ctl        (w_ctl),
            .i_left_live  (w_left),
            .i_right_live (w_rlive),
            .i_right_dst  (w_rdst),
            .i_head       (w_head),
            .i_first_dst  (w_dst[0]),
            .o_live       (w_live[g]),
            .o_dst        (w_dst[g])
        );
    end

    // Compare the head word against the held query
    assign w_match_cl = (w_head.client == r_client);
    assign w_match_uk = w_match_cl && (w_head.key == r_key);
    assign w_hit      = (r_op == OP_RESP) && (w_head.key == r_key) &&
                        ((w_head.btype == r_wild) || (w_head.btype == r_btype));
    assign w_remove   = ((r_op == OP_UNTRACK) && !r_found && w_match_uk) ||
                        ((r_op == OP_DROP) && w_match_cl);
    assign w_need_out = w_hit && r_pend_v;

    // Sequencer
    always_comb begin
        n_state       = r_state;
        n_sel         = r_sel;
        n_count       = r_count;
        n_ulen        = r_ulen;
        n_plen        = r_plen;
        n_removed     = r_removed;
        n_found       = r_found;
        n_pend_v      = r_pend_v;
        n_pend_client = r_pend_client;
        n_out_valid   = r_out_valid && i_out_stall;
        n_status      = r_status;
        n_dest        = r_dest;
        n_rem_out     = r_rem_out;
        n_last        = r_last;
        w_ctl         = '{sel: r_sel, push: 1'b0, shift: 1'b0, append: 1'b0,
                          rotate: 1'b0, plen: r_plen};
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_ulen    = r_count;
                    n_plen    = '0;
                    n_removed = '0;
                    n_found   = 1'b0;
                    n_pend_v  = 1'b0;
                    if ((t_opcode'(i_opcode) == OP_TRACK) ||
                        ((t_opcode'(i_opcode) == OP_RESP) &&
                         (i_expiry_time < i_now_time) && (i_block_type != r_data))) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_ulen == '0) begin
                    // Other bank now holds the list left after removals
                    n_sel   = !r_sel;
                    n_count = r_plen;
                    n_state = S_FIN;
                end else if (!w_need_out || w_out_free) begin
                    w_ctl.shift = 1'b1;
                    n_ulen      = r_ulen - CNT_W'(1);
                    if (w_remove) begin
                        w_ctl.rotate = (r_plen != '0);
                        n_removed    = r_removed + CNT_W'(1);
                        n_found      = 1'b1;
                    end else begin
                        w_ctl.append = 1'b1;
                        n_plen       = r_plen + CNT_W'(1);
                    end
                    if (w_hit) begin
                        n_pend_v      = 1'b1;
                        n_pend_client = w_head.client;
                    end
                    if (w_need_out) begin
                        n_out_valid = 1'b1;
                        n_status    = ST_DELIVER;
                        n_dest      = r_pend_client;
                        n_rem_out   = '0;
                        n_last      = 1'b0;
                    end
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_dest      = '0;
                    n_rem_out   = r_removed;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                    case (r_op)
                        OP_TRACK: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                w_ctl.push = 1'b1;
                                n_count    = r_count + CNT_W'(1);
                                n_status   = ST_DONE;
                            end
                        end
                        OP_UNTRACK: begin
                            n_status = r_found ? ST_DONE : ST_NOT_FOUND;
                        end
                        OP_DROP: begin
                            n_status = ST_DONE;
                        end
                        default: begin
                            if (r_expired) begin
                                n_status = ST_EXPIRED;
                            end else if (r_pend_v) begin
                                n_status = ST_DELIVER;
                                n_dest   = r_pend_client;
                            end else begin
                                n_status = ST_NO_MATCH;
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= 1'b0;
            r_count     <= '0;
            r_ulen      <= '0;
            r_plen      <= '0;
            r_removed   <= '0;
            r_found     <= 1'b0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
            r_wild      <= 8'd0;
            r_data      <= 8'd1;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_count     <= n_count;
            r_ulen      <= n_ulen;
            r_plen      <= n_plen;
            r_removed   <= n_removed;
            r_found     <= n_found;
            r_pend_v    <= n_pend_v;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr && (paddr[2] == REG_WILDCARD)) begin
                r_wild <= pwdata[7:0];
            end
            if (w_cfg_wr && (paddr[2] == REG_DATA)) begin
                r_data <= pwdata[7:0];
            end
        end
    end

    // Hold the query and the output word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= t_opcode'(i_opcode);
            r_key     <= i_key[KEY_BITS-1:0];
            r_btype   <= i_block_type;
            r_client  <= i_client_id;
            r_expired <= (i_expiry_time < i_now_time) && (i_block_type != r_data);
        end
        r_pend_client <= n_pend_client;
        r_status      <= n_status;
        r_dest        <= n_dest;
        r_rem_out     <= n_rem_out;
        r_last        <= n_last;
    end

    // Configuration port
    assign w_cfg_wr = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign prdata   = {24'd0, (paddr[2] == REG_DATA) ? r_data : r_wild};

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_dest_client   = r_dest;
    assign o_removed_count = 7'(r_rem_out);
    assign o_last          = r_last;

endmodule

FILE: hw/rtl/qmt_checker.sv
`include "assert_macros.svh"

module qmt_checker import qmt_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_status,
    input logic [7:0] o_dest_client,
    input logic       o_last
);

    // Hold a stalled output word
    `QMT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_status) && $stable(o_dest_client))
    // Only one item in flight
    `QMT_ASSERT_NXT(a_one_item, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // Anything but deliver closes its item
    `QMT_ASSERT_IMP(a_last_word, i_clk, i_rst_n, o_out_valid && (o_status != ST_DELIVER), o_last)
    // Client is named only on deliver
    `QMT_ASSERT_IMP(a_dest_zero, i_clk, i_rst_n, o_out_valid && (o_status != ST_DELIVER), o_dest_client == 8'd0)

endmodule

bind query_match_table qmt_checker u_qmt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_dest_client (o_dest_client),
    .o_last        (o_last)
);
